>>> rtl/sag_bit_permutation_top_defines.svh
// Assertion macros shared by the permutation RTL.
`ifndef SAG_BIT_PERMUTATION_TOP_DEFINES_SVH
`define SAG_BIT_PERMUTATION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define SAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be seen outside reset.
`define SAG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SAG_ASSERT(lbl, prop, msg)
`define SAG_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/sag_pkg.sv
package sag_pkg;

  // Word and register geometry
  localparam int SAG_WORD_BITS = 64;
  localparam int SAG_DATA_BITS = 64;
  localparam int SAG_STAGES    = 6;
  localparam int SAG_REG_SHIFT = 3;
  localparam int SAG_ADDR_BITS = $clog2(SAG_STAGES << SAG_REG_SHIFT);
  localparam int SAG_IDX_BITS  = SAG_ADDR_BITS - SAG_REG_SHIFT;

  typedef logic [SAG_DATA_BITS-1:0]                  sag_word_t;
  typedef logic [SAG_ADDR_BITS-1:0]                  sag_addr_t;
  typedef logic [SAG_IDX_BITS-1:0]                   sag_idx_t;
  typedef logic [SAG_STAGES-1:0][SAG_DATA_BITS-1:0]  sag_ctl_t;

endpackage

>>> rtl/sag_cfg.sv
module sag_cfg import sag_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  sag_addr_t paddr,
  input  sag_word_t pwdata,
  output sag_word_t prdata,
  output logic      pready,
  output sag_ctl_t  ctl
);

  sag_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[SAG_ADDR_BITS-1:SAG_REG_SHIFT];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write a stage control word; drop writes beyond the last stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (wr_en && (32'(idx) < SAG_STAGES)) begin
      ctl[idx] <= pwdata;
    end
  end

  // Read back the addressed control word
  always_comb begin
    prdata = '0;
    if (32'(idx) < SAG_STAGES) begin
      prdata = ctl[idx];
    end
  end

endmodule

>>> rtl/sag_step.sv
module sag_step import sag_pkg::*; #(
  parameter int WORD_BITS = SAG_WORD_BITS,
  parameter int SHIFT     = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] x_in,
  input  logic [WORD_BITS-1:0] m_in,
  input  logic [WORD_BITS-1:0] mk_in,
  output logic [WORD_BITS-1:0] x_out,
  output logic [WORD_BITS-1:0] m_out,
  output logic [WORD_BITS-1:0] mk_out
);

  localparam int LEVELS = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] mp;
  logic [WORD_BITS-1:0] mv;
  logic [WORD_BITS-1:0] t;

  // Prefix parity of the zero-run mask picks the bits that move by SHIFT
  always_comb begin
    mp = mk_in;
    for (int j = 0; j < LEVELS; j++) begin
      mp = mp ^ (mp << (1 << j));
    end
    mv = mp & m_in;
    t  = x_in & mv;
  end

  // Move selected data and mask bits down by SHIFT
  always_ff @(posedge clk) begin
    if (en) begin
      x_out  <= (x_in ^ t) | (t >> SHIFT);
      m_out  <= (m_in ^ mv) | (mv >> SHIFT);
      mk_out <= mk_in & ~mp;
    end
  end

endmodule

>>> rtl/sag_stage.sv
`include "sag_bit_permutation_top_defines.svh"

module sag_stage import sag_pkg::*; #(
  parameter int WORD_BITS = SAG_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [WORD_BITS-1:0] in_word,
  input  logic [WORD_BITS-1:0] ctl,
  output logic                 out_valid,
  output logic [WORD_BITS-1:0] out_word
);

  localparam int STEPS = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] ctl_rev;
  logic [WORD_BITS-1:0] word_rev;
  logic [STEPS:0][WORD_BITS-1:0] lo_x, lo_m, lo_mk;
  logic [STEPS:0][WORD_BITS-1:0] hi_x, hi_m, hi_mk;
  logic [STEPS-1:0] vld;

  // Mirror word and mask so the high group compresses toward the top
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      ctl_rev[b]  = ctl[WORD_BITS-1-b];
      word_rev[b] = in_word[WORD_BITS-1-b];
    end
  end

  // Seed both lanes: low lane takes zero-marked bits, high lane one-marked bits
  assign lo_m[0]  = ~ctl;
  assign lo_x[0]  = in_word & ~ctl;
  assign lo_mk[0] = ctl << 1;
  assign hi_m[0]  = ctl_rev;
  assign hi_x[0]  = word_rev & ctl_rev;
  assign hi_mk[0] = (~ctl_rev) << 1;

  // One register stage per compress step, both lanes in parallel
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    sag_step #(.WORD_BITS(WORD_BITS), .SHIFT(1 << i)) u_lo (
      .clk    (clk),
      .en     (en),
      .x_in   (lo_x[i]),
      .m_in   (lo_m[i]),
      .mk_in  (lo_mk[i]),
      .x_out  (lo_x[i+1]),
      .m_out  (lo_m[i+1]),
      .mk_out (lo_mk[i+1])
    );
    sag_step #(.WORD_BITS(WORD_BITS), .SHIFT(1 << i)) u_hi (
      .clk    (clk),
      .en     (en),
      .x_in   (hi_x[i]),
      .m_in   (hi_m[i]),
      .mk_in  (hi_mk[i]),
      .x_out  (hi_x[i+1]),
      .m_out  (hi_m[i+1]),
      .mk_out (hi_mk[i+1])
    );
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld[STEPS-1];

  // Merge: low group at the bottom, mirrored high group back at the top
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      out_word[b] = lo_x[STEPS][b] | hi_x[STEPS][WORD_BITS-1-b];
    end
  end

  `SAG_ASSERT(a_stall_holds_valid, !en |=> $stable(vld), "valid bits moved during stall")

endmodule

>>> rtl/sag_obuf.sv
`include "sag_bit_permutation_top_defines.svh"

module sag_obuf import sag_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  sag_word_t in_data,
  output logic      ready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output sag_word_t m_tdata
);

  logic      skid_valid;
  sag_word_t skid_data;
  logic      pop;

  assign pop   = m_tvalid && m_tready;
  assign ready = !skid_valid;

  // Hold control of the output register and the skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        m_tvalid <= 1'b0;
      end
    end else if (push) begin
      if (m_tvalid) begin
        skid_valid <= 1'b1;
      end else begin
        m_tvalid <= 1'b1;
      end
    end
  end

  // Load payload: refill from skid first, else from the pipeline
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      m_tdata <= skid_data;
    end else if (push && (pop || !m_tvalid)) begin
      m_tdata <= in_data;
    end
    if (push && m_tvalid && !pop) begin
      skid_data <= in_data;
    end
  end

  `SAG_ASSERT_NEVER(a_push_into_full, push && skid_valid, "transfer pushed into full skid")
  `SAG_ASSERT(a_skid_needs_out, skid_valid |-> m_tvalid, "skid holds data with empty output")

endmodule

>>> rtl/sag_bit_permutation_top.sv
// Six-stage sheep-and-goats bit permutation, one word per cycle while the output is not stalled.
// Each compress step of each stage is registered, and the output buffer registers the result.
// Throughput: one word per cycle unless m_tready stalls the output;
//   a 2-entry output buffer keeps s_tready registered.
// Reset (rst, synchronous): control words clear to zero, pipeline and output empty.
module sag_bit_permutation_top import sag_pkg::*; #(
  parameter int WORD_BITS = SAG_WORD_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  sag_word_t s_tdata,   // [63:0] data_word
  output logic      m_tvalid,
  input  logic      m_tready,
  output sag_word_t m_tdata,   // [63:0] permuted_word
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  sag_addr_t paddr,
  input  sag_word_t pwdata,
  output sag_word_t prdata,
  output logic      pready
);

  sag_ctl_t                                ctl;
  logic [SAG_STAGES:0]                     stage_valid;
  logic [SAG_STAGES:0][WORD_BITS-1:0]      stage_word;
  logic                                    en;

  sag_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  // Take an input transfer whenever the pipeline advances
  assign s_tready       = en;
  assign stage_valid[0] = s_tvalid && en;
  assign stage_word[0]  = s_tdata[WORD_BITS-1:0];

  // Chain the six sheep-and-goats stages
  for (genvar s = 0; s < SAG_STAGES; s++) begin : g_stage
    sag_stage #(.WORD_BITS(WORD_BITS)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_valid[s]),
      .in_word   (stage_word[s]),
      .ctl       (ctl[s][WORD_BITS-1:0]),
      .out_valid (stage_valid[s+1]),
      .out_word  (stage_word[s+1])
    );
  end

  sag_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (en && stage_valid[SAG_STAGES]),
    .in_data  (SAG_DATA_BITS'(stage_word[SAG_STAGES])),
    .ready    (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
